// ===== src/assert_macros.svh =====
// Assertion macros for the controller module.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  `ASSERT_IMPL(label, clk, rst_n, !(prop))
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== src/sdspi_pkg.sv =====
// Types and constants of the SD-card SPI host controller.
// Depends on nothing.
package sdspi_pkg;
  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_C0, PH_C8, PH_R7, PH_C55, PH_C41, PH_SLEEP,
    PH_C58, PH_OCR, PH_C16, PH_C17, PH_C24, PH_C9, PH_RTOK, PH_CTOK,
    PH_RDATA, PH_CSD, PH_WDATA, PH_BUSY
  } phase_t;

  localparam logic [2:0] CMD_INIT = 3'd1;
  localparam logic [2:0] CMD_READ = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_CAP = 3'd4;

  localparam logic [1:0] CFG_RETRY = 2'd0;
  localparam logic [1:0] CFG_TOKEN = 2'd1;
  localparam logic [1:0] CFG_BUSY = 2'd2;
  localparam logic [1:0] CFG_GAP = 2'd3;

  localparam int BLOCK_BYTES = 512;
  localparam int CSD_BYTES = 16;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic chip_select;
    logic read_valid;
    logic [7:0] read_data;
    logic write_taken;
    logic busy_res;
    logic done_res;
    logic failed;
    logic [31:0] sector_count;
    logic fast_clock;
  } result_t;

  function automatic logic [31:0] decode_csd(input logic [7:0] d [CSD_BYTES]);
    logic [21:0] c2;
    logic [23:0] n;
    logic [3:0] bl;
    logic [11:0] cs;
    logic [2:0] m;
    logic [5:0] sh;
    logic [63:0] bytes;
    c2 = {d[7][5:0], d[8], d[9]};
    n = {2'b00, c2} + 24'd1;
    bl = d[5][3:0];
    cs = {d[6][1:0], d[7], d[8][7:6]};
    m = {d[9][1:0], d[10][7]};
    sh = 6'(m) + 6'd2 + 6'(bl);
    bytes = {51'd0, {1'b0, cs} + 13'd1} << sh;
    if (d[0][7:6] == 2'd1) begin
      decode_csd = (n[23:22] != 2'b00) ? 32'hFFFF_FFFF : {n[21:0], 10'd0};
    end else begin
      decode_csd = bytes[40:9];
    end
  endfunction
endpackage

// ===== src/sdspi_cfg.sv =====
// Configuration register file of the SD-card SPI host controller.
// Depends on sdspi_pkg.
module sdspi_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic [15:0] retry_limit,
  output logic [15:0] token_limit,
  output logic [19:0] busy_limit,
  output logic [15:0] gap_bytes
);
  logic [15:0] retry_r, token_r, gap_r;
  logic [19:0] busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r <= 16'd2000;
      token_r <= 16'd20000;
      busy_r <= 20'd500000;
      gap_r <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::CFG_RETRY: retry_r <= cfg_data[15:0];
        sdspi_pkg::CFG_TOKEN: token_r <= cfg_data[15:0];
        sdspi_pkg::CFG_BUSY: busy_r <= cfg_data;
        sdspi_pkg::CFG_GAP: gap_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign retry_limit = retry_r;
  assign token_limit = token_r;
  assign busy_limit = busy_r;
  assign gap_bytes = gap_r;
endmodule

// ===== src/sd_spi_host_controller.sv =====
// SD-card SPI-mode host controller, top level: sequencer and result register.
// Depends on sdspi_pkg, sdspi_cfg and assert_macros.svh.
// Each transaction is one SPI byte exchange; a new transaction can be accepted every
// cycle, and a result waits in the output register while the next is taken only when
// that register is free or being emptied in the same cycle.
`include "assert_macros.svh"
module sd_spi_host_controller #(
  parameter int RESPONSE_WAIT_BYTES = 8,
  parameter int WAKE_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_block_number,
  input  logic [7:0]  in_miso_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_mosi_byte,
  output logic        out_chip_select,
  output logic        out_read_valid,
  output logic [7:0]  out_read_data,
  output logic        out_write_taken,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_failed,
  output logic [31:0] out_sector_count,
  output logic        out_fast_clock
);
  logic [15:0] retry_limit, token_limit, gap_bytes;
  logic [19:0] busy_limit;

  sdspi_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .retry_limit, .token_limit, .busy_limit, .gap_bytes
  );

  sdspi_pkg::phase_t phase_r, phase_nxt;
  logic [19:0] cnt_r, cnt_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [7:0] last_r, last_nxt;
  logic v2_r, v2_nxt, blk_r, blk_nxt, fast_r, fast_nxt;
  logic [7:0] csd_r [sdspi_pkg::CSD_BYTES];
  logic csd_we;
  sdspi_pkg::result_t res_r, res_nxt;
  logic out_valid_r;
  logic accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept = in_valid && !in_stall;

  function automatic logic [5:0] cmd_idx(input sdspi_pkg::phase_t p);
    unique case (p)
      sdspi_pkg::PH_C0: cmd_idx = 6'd0;
      sdspi_pkg::PH_C8: cmd_idx = 6'd8;
      sdspi_pkg::PH_C55: cmd_idx = 6'd55;
      sdspi_pkg::PH_C41: cmd_idx = 6'd41;
      sdspi_pkg::PH_C58: cmd_idx = 6'd58;
      sdspi_pkg::PH_C16: cmd_idx = 6'd16;
      sdspi_pkg::PH_C17: cmd_idx = 6'd17;
      sdspi_pkg::PH_C24: cmd_idx = 6'd24;
      default: cmd_idx = 6'd9;
    endcase
  endfunction

  always_comb begin
    logic [31:0] addr;
    logic run_cmd, do_r1;
    sdspi_pkg::phase_t cp;
    logic [19:0] k;
    logic [31:0] a;
    logic [5:0] c;
    logic [7:0] miso;
    logic [31:0] wrapped;
    phase_nxt = phase_r; cnt_nxt = cnt_r; retry_nxt = retry_r; arg_nxt = arg_r;
    last_nxt = last_r; v2_nxt = v2_r; blk_nxt = blk_r; fast_nxt = fast_r;
    csd_we = 1'b0;
    res_nxt = '0;
    res_nxt.mosi_byte = 8'hFF; res_nxt.chip_select = 1'b1;
    miso = in_miso_byte;
    wrapped = {in_block_number[22:0], 9'd0};
    addr = blk_r ? in_block_number : wrapped;
    run_cmd = 1'b0;
    do_r1 = 1'b0;
    c = '0;
    cp = phase_r; k = cnt_r; a = arg_r;
    unique case (phase_r)
      sdspi_pkg::PH_IDLE: begin
        if (in_command == sdspi_pkg::CMD_INIT) begin
          v2_nxt = 1'b0; blk_nxt = 1'b0; fast_nxt = 1'b0;
          phase_nxt = sdspi_pkg::PH_WAKE; cnt_nxt = 20'd1;
        end else if (in_command == sdspi_pkg::CMD_READ) begin
          run_cmd = 1'b1; cp = sdspi_pkg::PH_C17; k = '0; a = addr;
        end else if (in_command == sdspi_pkg::CMD_WRITE) begin
          run_cmd = 1'b1; cp = sdspi_pkg::PH_C24; k = '0; a = addr;
        end else if (in_command == sdspi_pkg::CMD_CAP) begin
          run_cmd = 1'b1; cp = sdspi_pkg::PH_C9; k = '0; a = '0;
        end
      end
      sdspi_pkg::PH_WAKE: begin
        if (cnt_r < 20'(WAKE_BYTES)) begin
          cnt_nxt = cnt_r + 20'd1;
        end else begin
          run_cmd = 1'b1; cp = sdspi_pkg::PH_C0; k = '0; a = '0;
        end
      end
      sdspi_pkg::PH_R7: begin
        if (cnt_r < 20'd4) begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else if (miso != 8'hAA) begin
          res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
          phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end else begin
          retry_nxt = retry_limit; phase_nxt = sdspi_pkg::PH_C55;
          cnt_nxt = '0; arg_nxt = '0;
        end
      end
      sdspi_pkg::PH_SLEEP: begin
        if (cnt_r < {4'd0, gap_bytes}) begin
          cnt_nxt = cnt_r + 20'd1;
        end else begin
          retry_nxt = retry_r - 16'd1;
          if (last_r == 8'h01 && retry_r != 16'd1) begin
            run_cmd = 1'b1; cp = sdspi_pkg::PH_C55; k = '0; a = '0;
          end else if (last_r != 8'h00) begin
            res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
            phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
          end else if (v2_r) begin
            run_cmd = 1'b1; cp = sdspi_pkg::PH_C58; k = '0; a = '0;
          end else begin
            run_cmd = 1'b1; cp = sdspi_pkg::PH_C16; k = '0;
            a = 32'(sdspi_pkg::BLOCK_BYTES);
          end
        end
      end
      sdspi_pkg::PH_OCR: begin
        if (cnt_r == 20'd1) blk_nxt = miso[6];
        if (cnt_r < 20'd4) begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else if (blk_r) begin
          fast_nxt = 1'b1; res_nxt.done_res = 1'b1;
          phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end else begin
          phase_nxt = sdspi_pkg::PH_C16; cnt_nxt = '0;
          arg_nxt = 32'(sdspi_pkg::BLOCK_BYTES);
        end
      end
      sdspi_pkg::PH_RTOK, sdspi_pkg::PH_CTOK: begin
        if (miso == 8'hFE) begin
          phase_nxt = (phase_r == sdspi_pkg::PH_RTOK) ? sdspi_pkg::PH_RDATA
                                                     : sdspi_pkg::PH_CSD;
          cnt_nxt = '0; res_nxt.chip_select = 1'b0;
        end else if (cnt_r >= {4'd0, token_limit}) begin
          res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
          phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end
      end
      sdspi_pkg::PH_RDATA: begin
        if (cnt_r < 20'(sdspi_pkg::BLOCK_BYTES)) begin
          res_nxt.read_valid = 1'b1; res_nxt.read_data = miso;
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else if (cnt_r == 20'(sdspi_pkg::BLOCK_BYTES)) begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else begin
          res_nxt.done_res = 1'b1; phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end
      end
      sdspi_pkg::PH_CSD: begin
        if (cnt_r < 20'(sdspi_pkg::CSD_BYTES)) begin
          csd_we = 1'b1; cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else if (cnt_r == 20'(sdspi_pkg::CSD_BYTES)) begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end else begin
          res_nxt.sector_count = sdspi_pkg::decode_csd(csd_r);
          res_nxt.done_res = 1'b1; phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end
      end
      sdspi_pkg::PH_WDATA: begin
        res_nxt.chip_select = 1'b0;
        cnt_nxt = cnt_r + 20'd1;
        if (cnt_r == 20'd0) begin
          res_nxt.mosi_byte = 8'hFE;
        end else if (cnt_r <= 20'(sdspi_pkg::BLOCK_BYTES)) begin
          res_nxt.mosi_byte = in_write_byte; res_nxt.write_taken = 1'b1;
        end else if (cnt_r > 20'(sdspi_pkg::BLOCK_BYTES + 3)) begin
          if (miso[4:0] != 5'h05) begin
            res_nxt.chip_select = 1'b1;
            res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
            phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
          end else if (busy_limit == 20'd0) begin
            res_nxt.chip_select = 1'b1; res_nxt.done_res = 1'b1;
            phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
          end else begin
            phase_nxt = sdspi_pkg::PH_BUSY; cnt_nxt = 20'd1;
          end
        end
      end
      sdspi_pkg::PH_BUSY: begin
        if (miso != 8'h00 || cnt_r >= busy_limit) begin
          res_nxt.done_res = 1'b1; phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 20'd1; res_nxt.chip_select = 1'b0;
        end
      end
      default: begin
        run_cmd = 1'b1;
      end
    endcase

    if (run_cmd) begin
      c = cmd_idx(cp);
      phase_nxt = cp; arg_nxt = a; res_nxt.chip_select = 1'b0;
      cnt_nxt = k + 20'd1;
      do_r1 = 1'b0;
      if (k == 20'd0) begin
        res_nxt.mosi_byte = 8'hFF;
      end else if (k == 20'd1) begin
        res_nxt.mosi_byte = {2'b01, c};
      end else if (k <= 20'd5) begin
        res_nxt.mosi_byte = 8'(a >> (5'd8 * (5'd5 - k[4:0])));
      end else if (k == 20'd6) begin
        res_nxt.mosi_byte = (c == 6'd0) ? 8'h95 : ((c == 6'd8) ? 8'h87 : 8'h01);
      end else if (k == 20'd7) begin
        res_nxt.mosi_byte = 8'hFF;
      end else begin
        do_r1 = !miso[7] || (k - 20'd7 >= 20'(RESPONSE_WAIT_BYTES));
      end
      if (do_r1) begin
        priority case (cp)
          sdspi_pkg::PH_C0: begin
            if (miso != 8'h01) begin
              res_nxt.chip_select = 1'b1; res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
              phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
            end else begin
              res_nxt.chip_select = 1'b1; phase_nxt = sdspi_pkg::PH_C8;
              cnt_nxt = '0; arg_nxt = 32'h1AA;
            end
          end
          sdspi_pkg::PH_C8: begin
            if (miso == 8'h01) begin
              v2_nxt = 1'b1; phase_nxt = sdspi_pkg::PH_R7; cnt_nxt = 20'd1;
            end else begin
              v2_nxt = 1'b0; res_nxt.chip_select = 1'b1; retry_nxt = retry_limit;
              phase_nxt = sdspi_pkg::PH_C55; cnt_nxt = '0; arg_nxt = '0;
            end
          end
          sdspi_pkg::PH_C55: begin
            res_nxt.chip_select = 1'b1; phase_nxt = sdspi_pkg::PH_C41; cnt_nxt = '0;
            arg_nxt = v2_r ? 32'h4000_0000 : 32'd0;
          end
          sdspi_pkg::PH_C41: begin
            last_nxt = miso; res_nxt.chip_select = 1'b1;
            phase_nxt = sdspi_pkg::PH_SLEEP; cnt_nxt = '0;
          end
          sdspi_pkg::PH_C58: begin
            phase_nxt = sdspi_pkg::PH_OCR; cnt_nxt = 20'd1;
          end
          sdspi_pkg::PH_C16: begin
            res_nxt.chip_select = 1'b1; res_nxt.done_res = 1'b1;
            phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
            if (miso != 8'h00) res_nxt.failed = 1'b1;
            else fast_nxt = 1'b1;
          end
          sdspi_pkg::PH_C17, sdspi_pkg::PH_C9: begin
            if (miso != 8'h00 || token_limit == 16'd0) begin
              res_nxt.chip_select = 1'b1; res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
              phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
            end else begin
              phase_nxt = (cp == sdspi_pkg::PH_C17) ? sdspi_pkg::PH_RTOK
                                                    : sdspi_pkg::PH_CTOK;
              cnt_nxt = 20'd1;
            end
          end
          default: begin
            if (miso != 8'h00) begin
              res_nxt.chip_select = 1'b1; res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1;
              phase_nxt = sdspi_pkg::PH_IDLE; cnt_nxt = '0;
            end else begin
              phase_nxt = sdspi_pkg::PH_WDATA; cnt_nxt = '0;
            end
          end
        endcase
      end
    end
    res_nxt.busy_res = (phase_nxt != sdspi_pkg::PH_IDLE);
    res_nxt.fast_clock = fast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE;
      cnt_r <= '0; retry_r <= '0; arg_r <= '0; last_r <= 8'hFF;
      v2_r <= 1'b0; blk_r <= 1'b0; fast_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt; cnt_r <= cnt_nxt; retry_r <= retry_nxt;
        arg_r <= arg_nxt; last_r <= last_nxt;
        v2_r <= v2_nxt; blk_r <= blk_nxt; fast_r <= fast_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
      if (csd_we) csd_r[cnt_r[3:0]] <= in_miso_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mosi_byte = res_r.mosi_byte;
  assign out_chip_select = res_r.chip_select;
  assign out_read_valid = res_r.read_valid;
  assign out_read_data = res_r.read_data;
  assign out_write_taken = res_r.write_taken;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_failed = res_r.failed;
  assign out_sector_count = res_r.sector_count;
  assign out_fast_clock = res_r.fast_clock;

  `ASSERT_NEVER(a_fail_done, clk, rst_n, out_valid && out_failed && !out_done_res)
  `ASSERT_IMPL(a_done_idle, clk, rst_n, (out_valid && out_done_res) |-> !out_busy_res)
  `ASSERT_IMPL(a_done_release, clk, rst_n, (out_valid && out_done_res) |-> out_chip_select)
  `ASSERT_IMPL(a_fast_tracks, clk, rst_n, (out_valid && !out_stall) |=> $stable(fast_r) || $past(accept))
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sd_spi_host_controller with a card-like responder.
// Depends on sdspi_pkg and the controller RTL; holds its own sequencer predictor in a scoreboard class.
module tb_top;
  localparam int WATCHDOG_CYCLES = 2000;

  class sd_scoreboard;
    logic [15:0] retry_lim, token_lim, gap_len;
    logic [19:0] busy_lim;
    sdspi_pkg::phase_t ph;
    logic [19:0] cnt;
    logic [15:0] retries;
    logic [31:0] arg;
    logic [7:0] last_r1;
    logic v2, blk_addr, fast;
    logic [7:0] csd [sdspi_pkg::CSD_BYTES];
    sdspi_pkg::result_t r;
    sdspi_pkg::result_t pending_q[$];
    int errors;

    function new();
      retry_lim = 16'd2000; token_lim = 16'd20000; busy_lim = 20'd500000; gap_len = 16'd50;
      ph = sdspi_pkg::PH_IDLE; cnt = '0; retries = '0; arg = '0; last_r1 = 8'hFF;
      v2 = 0; blk_addr = 0; fast = 0; errors = 0;
      foreach (csd[i]) csd[i] = '0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [19:0] v);
      case (idx)
        sdspi_pkg::CFG_RETRY: retry_lim = v[15:0];
        sdspi_pkg::CFG_TOKEN: token_lim = v[15:0];
        sdspi_pkg::CFG_BUSY:  busy_lim = v;
        default:   gap_len = v[15:0];
      endcase
    endfunction

    function void emit(logic [7:0] b, logic cs);
      r.mosi_byte = b; r.chip_select = cs;
    endfunction

    function void finish_op(logic fail);
      r.done_res = 1; r.failed = fail; emit(8'hFF, 1);
      ph = sdspi_pkg::PH_IDLE; cnt = '0;
    endfunction

    function void begin_cmd(sdspi_pkg::phase_t p, logic [31:0] a);
      ph = p; cnt = '0; arg = a;
    endfunction

    function void begin_acmd();
      retries = retry_lim;
      begin_cmd(sdspi_pkg::PH_C55, 0);
    endfunction

    function void poll_token();
      if (cnt >= 20'(token_lim)) begin
        finish_op(1);
        return;
      end
      cnt++; emit(8'hFF, 0);
    endfunction

    function void poll_busy();
      if (cnt >= busy_lim) begin
        finish_op(0);
        return;
      end
      cnt++; emit(8'hFF, 0);
    endfunction

    function logic [5:0] cmd_num();
      case (ph)
        sdspi_pkg::PH_C0: return 6'd0;
        sdspi_pkg::PH_C8: return 6'd8;
        sdspi_pkg::PH_C55: return 6'd55;
        sdspi_pkg::PH_C41: return 6'd41;
        sdspi_pkg::PH_C58: return 6'd58;
        sdspi_pkg::PH_C16: return 6'd16;
        sdspi_pkg::PH_C17: return 6'd17;
        sdspi_pkg::PH_C24: return 6'd24;
        default: return 6'd9;
      endcase
    endfunction

    function void take_r1(logic [7:0] r1);
      case (ph)
        sdspi_pkg::PH_C0: begin
          if (r1 != 8'h01) finish_op(1);
          else begin
            emit(8'hFF, 1); begin_cmd(sdspi_pkg::PH_C8, 32'h1AA);
          end
        end
        sdspi_pkg::PH_C8: begin
          if (r1 == 8'h01) begin
            v2 = 1; emit(8'hFF, 0); ph = sdspi_pkg::PH_R7; cnt = 20'd1;
          end else begin
            v2 = 0; emit(8'hFF, 1); begin_acmd();
          end
        end
        sdspi_pkg::PH_C55: begin
          emit(8'hFF, 1); begin_cmd(sdspi_pkg::PH_C41, v2 ? 32'h4000_0000 : 32'h0);
        end
        sdspi_pkg::PH_C41: begin
          last_r1 = r1; emit(8'hFF, 1); ph = sdspi_pkg::PH_SLEEP; cnt = '0;
        end
        sdspi_pkg::PH_C58: begin
          emit(8'hFF, 0); ph = sdspi_pkg::PH_OCR; cnt = 20'd1;
        end
        sdspi_pkg::PH_C16: begin
          if (r1 != 0) finish_op(1);
          else begin
            fast = 1; finish_op(0);
          end
        end
        sdspi_pkg::PH_C17, sdspi_pkg::PH_C9: begin
          if (r1 != 0) finish_op(1);
          else begin
            ph = (ph == sdspi_pkg::PH_C17) ? sdspi_pkg::PH_RTOK : sdspi_pkg::PH_CTOK;
            cnt = '0; poll_token();
          end
        end
        default: begin
          if (r1 != 0) finish_op(1);
          else begin
            ph = sdspi_pkg::PH_WDATA; cnt = '0; emit(8'hFF, 0);
          end
        end
      endcase
    endfunction

    function void frame_byte(logic [7:0] miso);
      logic [19:0] k;
      logic [5:0] c;
      k = cnt; c = cmd_num();
      if (k == 0) emit(8'hFF, 0);
      else if (k == 1) emit({2'b01, c}, 0);
      else if (k <= 5) emit(8'(arg >> (8 * (5 - k))), 0);
      else if (k == 6) emit(c == 0 ? 8'h95 : (c == 8 ? 8'h87 : 8'h01), 0);
      else if (k == 7) emit(8'hFF, 0);
      else if (!miso[7] || k - 7 >= 8) begin
        take_r1(miso);
        return;
      end else emit(8'hFF, 0);
      cnt = k + 1;
    endfunction

    function logic [31:0] capacity();
      logic [63:0] n;
      logic [11:0] cs;
      if (csd[0][7:6] == 2'd1) begin
        n = (64'({csd[7][5:0], csd[8], csd[9]}) + 1) * 1024;
        return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
      end
      cs = {csd[6][1:0], csd[7], csd[8][7:6]};
      n = (64'(cs) + 1) << ({csd[9][1:0], csd[10][7]} + 2);
      n = n << csd[5][3:0];
      return n[40:9];
    endfunction

    function void note(logic [2:0] cmd, logic [31:0] blk, logic [7:0] miso, logic [7:0] wb);
      logic [31:0] addr;
      addr = blk_addr ? blk : blk * sdspi_pkg::BLOCK_BYTES;
      r = '0; r.mosi_byte = 8'hFF; r.chip_select = 1;
      case (ph)
        sdspi_pkg::PH_IDLE: begin
          if (cmd == sdspi_pkg::CMD_INIT) begin
            v2 = 0; blk_addr = 0; fast = 0; ph = sdspi_pkg::PH_WAKE; cnt = 20'd1;
            emit(8'hFF, 1);
          end else if (cmd == sdspi_pkg::CMD_READ) begin
            begin_cmd(sdspi_pkg::PH_C17, addr); frame_byte(miso);
          end else if (cmd == sdspi_pkg::CMD_WRITE) begin
            begin_cmd(sdspi_pkg::PH_C24, addr); frame_byte(miso);
          end else if (cmd == sdspi_pkg::CMD_CAP) begin
            begin_cmd(sdspi_pkg::PH_C9, 0); frame_byte(miso);
          end
        end
        sdspi_pkg::PH_WAKE: begin
          if (cnt < 10) begin
            cnt++; emit(8'hFF, 1);
          end else begin
            begin_cmd(sdspi_pkg::PH_C0, 0); frame_byte(miso);
          end
        end
        sdspi_pkg::PH_R7: begin
          if (cnt < 4) begin
            cnt++; emit(8'hFF, 0);
          end else if (miso != 8'hAA) finish_op(1);
          else begin
            emit(8'hFF, 1); begin_acmd();
          end
        end
        sdspi_pkg::PH_SLEEP: begin
          if (cnt < 20'(gap_len)) begin
            cnt++; emit(8'hFF, 1);
          end else begin
            retries = retries - 1;
            if (last_r1 == 8'h01 && retries != 0) begin
              begin_cmd(sdspi_pkg::PH_C55, 0); frame_byte(miso);
            end else if (last_r1 != 0) finish_op(1);
            else if (v2) begin
              begin_cmd(sdspi_pkg::PH_C58, 0); frame_byte(miso);
            end else begin
              begin_cmd(sdspi_pkg::PH_C16, sdspi_pkg::BLOCK_BYTES); frame_byte(miso);
            end
          end
        end
        sdspi_pkg::PH_OCR: begin
          if (cnt == 1) blk_addr = miso[6];
          if (cnt < 4) begin
            cnt++; emit(8'hFF, 0);
          end else if (blk_addr) begin
            fast = 1; finish_op(0);
          end else begin
            emit(8'hFF, 1); begin_cmd(sdspi_pkg::PH_C16, sdspi_pkg::BLOCK_BYTES);
          end
        end
        sdspi_pkg::PH_RTOK, sdspi_pkg::PH_CTOK: begin
          if (miso == 8'hFE) begin
            ph = (ph == sdspi_pkg::PH_RTOK) ? sdspi_pkg::PH_RDATA : sdspi_pkg::PH_CSD;
            cnt = '0; emit(8'hFF, 0);
          end else poll_token();
        end
        sdspi_pkg::PH_RDATA: begin
          if (cnt < sdspi_pkg::BLOCK_BYTES) begin
            r.read_valid = 1; r.read_data = miso; cnt++; emit(8'hFF, 0);
          end else if (cnt == sdspi_pkg::BLOCK_BYTES) begin
            cnt++; emit(8'hFF, 0);
          end else finish_op(0);
        end
        sdspi_pkg::PH_CSD: begin
          if (cnt < sdspi_pkg::CSD_BYTES) begin
            csd[cnt[3:0]] = miso; cnt++; emit(8'hFF, 0);
          end else if (cnt == sdspi_pkg::CSD_BYTES) begin
            cnt++; emit(8'hFF, 0);
          end else begin
            r.sector_count = capacity(); finish_op(0);
          end
        end
        sdspi_pkg::PH_WDATA: begin
          if (cnt == 0) begin
            emit(8'hFE, 0); cnt++;
          end else if (cnt <= sdspi_pkg::BLOCK_BYTES) begin
            emit(wb, 0); r.write_taken = 1; cnt++;
          end else if (cnt <= sdspi_pkg::BLOCK_BYTES + 3) begin
            emit(8'hFF, 0); cnt++;
          end else if (miso[4:0] != 5'h05) finish_op(1);
          else begin
            ph = sdspi_pkg::PH_BUSY; cnt = '0; poll_busy();
          end
        end
        sdspi_pkg::PH_BUSY: begin
          if (miso != 0) finish_op(0);
          else poll_busy();
        end
        default: frame_byte(miso);
      endcase
      r.busy_res = (ph != sdspi_pkg::PH_IDLE);
      r.fast_clock = fast;
      pending_q.push_back(r);
    endfunction

    function void cmp(string f, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, f, e, a);
        errors++;
      end
    endfunction

    function void check(sdspi_pkg::result_t a);
      sdspi_pkg::result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0h", $time, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("mosi_byte", e.mosi_byte, a.mosi_byte);
      cmp("chip_select", e.chip_select, a.chip_select);
      cmp("read_valid", e.read_valid, a.read_valid);
      cmp("read_data", e.read_data, a.read_data);
      cmp("write_taken", e.write_taken, a.write_taken);
      cmp("busy_res", e.busy_res, a.busy_res);
      cmp("done_res", e.done_res, a.done_res);
      cmp("failed", e.failed, a.failed);
      cmp("sector_count", e.sector_count, a.sector_count);
      cmp("fast_clock", e.fast_clock, a.fast_clock);
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;
  logic in_valid, in_stall;
  logic [2:0] in_command;
  logic [31:0] in_block_number;
  logic [7:0] in_miso_byte, in_write_byte;
  logic out_valid, out_stall;
  wire sdspi_pkg::result_t res;

  sd_scoreboard sb;
  logic quiet;
  bit full_op;
  int stall_left;
  int idle_cycles;
  int items;

  sd_spi_host_controller uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_block_number(in_block_number), .in_miso_byte(in_miso_byte),
    .in_write_byte(in_write_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mosi_byte(res.mosi_byte), .out_chip_select(res.chip_select),
    .out_read_valid(res.read_valid), .out_read_data(res.read_data),
    .out_write_taken(res.write_taken), .out_busy_res(res.busy_res),
    .out_done_res(res.done_res), .out_failed(res.failed),
    .out_sector_count(res.sector_count), .out_fast_clock(res.fast_clock)
  );

  always begin
    clk = 1; #1;
    clk = 0; #1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check(res);
        stall_left = quiet ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("[sd_spi_host_controller] ERROR");
        $finish;
      end
    end
  end

  // Only full_op steers full block transfers (stray random bytes aside), which keeps the run short.
  function logic [7:0] card_byte();
    logic [7:0] rnd;
    rnd = 8'($urandom);
    if ($urandom_range(0, 15) == 0) return rnd;
    case (sb.ph)
      sdspi_pkg::PH_C0, sdspi_pkg::PH_C8, sdspi_pkg::PH_C55, sdspi_pkg::PH_C41,
      sdspi_pkg::PH_C58, sdspi_pkg::PH_C16, sdspi_pkg::PH_C17, sdspi_pkg::PH_C24,
      sdspi_pkg::PH_C9: begin
        if (sb.cnt < 8 || $urandom_range(0, 3) == 0) return 8'hFF;
        case (sb.ph)
          sdspi_pkg::PH_C0, sdspi_pkg::PH_C55: return 8'h01;
          sdspi_pkg::PH_C8: return $urandom_range(0, 1) ? 8'h01 : 8'h05;
          sdspi_pkg::PH_C41: return ($urandom_range(0, 9) < 5) ? 8'h01 :
                         ($urandom_range(0, 7) != 0 ? 8'h00 : 8'h04);
          sdspi_pkg::PH_C17: return (full_op || sb.token_lim <= 16'd64) ? 8'h00 : 8'h04;
          sdspi_pkg::PH_C24: return full_op ? 8'h00 : 8'h04;
          default: return 8'h00;
        endcase
      end
      sdspi_pkg::PH_R7: return (sb.cnt == 4) ? 8'hAA : rnd;
      sdspi_pkg::PH_RTOK: begin
        if (!full_op) return 8'hFF;
        return ($urandom_range(0, 4) == 0) ? 8'hFE : 8'hFF;
      end
      sdspi_pkg::PH_CTOK: return ($urandom_range(0, 4) == 0) ? 8'hFE : 8'hFF;
      sdspi_pkg::PH_WDATA: return {rnd[7:5], 5'h05};
      sdspi_pkg::PH_BUSY: return ($urandom_range(0, 3) == 0) ? (rnd | 8'h01) : 8'h00;
      default: return rnd;
    endcase
  endfunction

  task automatic push_item(logic [2:0] cmd, logic [31:0] blk, logic [7:0] wb);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_block_number <= blk;
    in_miso_byte <= card_byte();
    in_write_byte <= wb;
    do @(posedge clk); while (in_stall);
    sb.note(in_command, in_block_number, in_miso_byte, in_write_byte);
    items++;
  endtask

  function logic [31:0] pick_block();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_op(logic [2:0] cmd);
    quiet = ($urandom_range(0, 3) == 0);
    push_item(cmd, pick_block(), 8'($urandom));
    while (sb.ph != sdspi_pkg::PH_IDLE) push_item(3'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_cfg(idx, v);
  endtask

  task automatic set_all(logic [15:0] rl, logic [15:0] tl, logic [19:0] bl, logic [15:0] gl);
    drain();
    cfg_write(sdspi_pkg::CFG_RETRY, 20'(rl));
    cfg_write(sdspi_pkg::CFG_TOKEN, 20'(tl));
    cfg_write(sdspi_pkg::CFG_BUSY, bl);
    cfg_write(sdspi_pkg::CFG_GAP, 20'(gl));
  endtask

  task automatic random_ops(int n, bit with_init);
    int target;
    int pick;
    target = items + n;
    while (items < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && with_init) run_op(sdspi_pkg::CMD_INIT);
      else if (pick == 3) run_op(sdspi_pkg::CMD_READ);
      else if (pick == 4) run_op(sdspi_pkg::CMD_WRITE);
      else if (pick < 8) run_op(sdspi_pkg::CMD_CAP);
      else run_op(3'($urandom_range(0, 1) ? 0 : $urandom_range(5, 7)));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_command = '0; in_block_number = '0; in_miso_byte = '0;
    in_write_byte = '0; out_stall = 0; quiet = 0; full_op = 0;
    stall_left = 0; idle_cycles = 0; items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    set_all(16'd4, 16'd30, 20'd30, 16'd2);
    run_op(3'd0);
    run_op(3'd5);
    run_op(3'd6);
    run_op(3'd7);
    full_op = 1;
    run_op(sdspi_pkg::CMD_READ);
    full_op = 0;
    run_op(sdspi_pkg::CMD_INIT);
    run_op(sdspi_pkg::CMD_CAP);
    full_op = 1;
    run_op(sdspi_pkg::CMD_WRITE);
    full_op = 0;
    run_op(sdspi_pkg::CMD_INIT);
    run_op(sdspi_pkg::CMD_READ);

    set_all(16'd2000, 16'd20000, 20'd500000, 16'd50);
    random_ops(30, 1);
    set_all(16'd1, 16'd1, 20'd1, 16'd0);
    random_ops(30, 1);
    set_all(16'd0, 16'd0, 20'd0, 16'd0);
    random_ops(30, 1);
    set_all(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
    random_ops(20, 0);
    set_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
            20'($urandom_range(1, 40)), 16'($urandom_range(0, 6)));
    random_ops(30, 1);
    set_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
            20'($urandom_range(1, 40)), 16'($urandom_range(0, 6)));
    random_ops(30, 1);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[sd_spi_host_controller] OK");
    end else begin
      $display("[sd_spi_host_controller] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/sdspi_pkg.sv
src/sdspi_cfg.sv
src/sd_spi_host_controller.sv
tb/sv/tb_top.sv
